[hw/rtl/bpa_pkg.sv]
package bpa_pkg;

   localparam int NUM_ORDERS = 11;
   localparam int FRAME_W    = 16;
   localparam int NUM_FRAMES = 1 << FRAME_W;
   localparam int ORDER_W    = 4;
   localparam int LINK_W     = FRAME_W + 1;

   // link value with the top bit set means "no link"
   localparam logic [LINK_W-1:0] LINK_NONE = '1;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [ORDER_W-1:0] block_order;
      logic [FRAME_W-1:0] frame_index;
   } req_word_type;

   typedef struct packed {
      logic               status;
      logic [FRAME_W-1:0] result_frame;
      logic [ORDER_W-1:0] result_order;
   } rsp_word_type;

   typedef struct packed {
      logic               is_free;
      logic [ORDER_W-1:0] order;
   } meta_type;

   localparam int META_W = $bits(meta_type);

endpackage

[hw/rtl/bpa_ram.sv]
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/buddy_page_allocator.sv]
// Binary buddy page allocator: one word in, one word out. An allocate takes
// the front block of the lowest non-empty free list at or above the asked
// order and splits it down, pushing each upper half to its list front; a
// free merges with equal-order free buddies up to the top order and pushes
// the merged block. After reset a clearing pass zeroes every entry of the
// per-frame order/free memory; no request is taken during it, and nothing is
// free until software seeds memory with free requests. One request at a time
// runs through a small sequencer around three frame memories, each with one
// write port and one registered read port (next link, prev link, order/free).
// A finished result sits in the output register while the next request is
// taken.
module buddy_page_allocator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bpa_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bpa_pkg::rsp_word_type rsp_word
);

   localparam int FW = bpa_pkg::FRAME_W;
   localparam int OW = bpa_pkg::ORDER_W;
   localparam int LW = bpa_pkg::LINK_W;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,      // search list heads upward for a block
      ST_A_UNL,     // unlink the block found
      ST_A_SPLIT,   // push upper halves, one order per pass
      ST_F_CHK,     // double-free check
      ST_F_LOOP,    // look at the buddy
      ST_F_MRG,     // merge with buddy or stop
      ST_P_CHK,     // push: unlink if already on a list
      ST_P_LINK,    // push: link at list front
      ST_P_PREV,    // push: back link of old head
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [LW-1:0] head_ff [bpa_pkg::NUM_ORDERS];
   logic [LW-1:0] head_in [bpa_pkg::NUM_ORDERS];

   logic [OW-1:0] cur_ff, cur_in;
   logic [OW-1:0] ord_ff, ord_in;
   logic [FW-1:0] frm_ff, frm_in;       // freed/merged frame or allocated block
   logic [FW-1:0] pf_ff, pf_in;         // frame being pushed
   logic [OW-1:0] po_ff, po_in;         // its order
   logic [FW-1:0] h_ff, h_in;           // old list head during push
   logic          ret_alloc_ff, ret_alloc_in;
   logic [FW-1:0] clr_ff, clr_in;
   bpa_pkg::rsp_word_type res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   bpa_pkg::rsp_word_type rsp_ff, rsp_in;

   // memory ports
   logic          rd_en;
   logic [FW-1:0] rd_addr;
   logic          nx_we, pv_we, mt_we;
   logic [FW-1:0] nx_wa, pv_wa, mt_wa;
   logic [LW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
   bpa_pkg::meta_type mt_wd, mt_rd;
   logic [bpa_pkg::META_W-1:0] mt_rd_bits;

   logic [OW-1:0] cur_m1;
   logic [LW-1:0] half;
   logic [FW-1:0] buddy;

   assign mt_rd = bpa_pkg::meta_type'(mt_rd_bits);

   bpa_ram #(.WIDTH(LW), .DEPTH(bpa_pkg::NUM_FRAMES)) u_next_ram (
      .clock(clock), .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(nx_rd)
   );

   bpa_ram #(.WIDTH(LW), .DEPTH(bpa_pkg::NUM_FRAMES)) u_prev_ram (
      .clock(clock), .wr_en(pv_we), .wr_addr(pv_wa), .wr_data(pv_wd),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(pv_rd)
   );

   bpa_ram #(.WIDTH(bpa_pkg::META_W), .DEPTH(bpa_pkg::NUM_FRAMES)) u_meta_ram (
      .clock(clock), .wr_en(mt_we), .wr_addr(mt_wa), .wr_data(mt_wd),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(mt_rd_bits)
   );

   assign cur_m1 = cur_ff - OW'(1);
   assign half   = {1'b0, frm_ff} + (LW'(1) << cur_m1);
   assign buddy  = frm_ff ^ (FW'(1) << ord_ff);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      cur_in       = cur_ff;
      ord_in       = ord_ff;
      frm_in       = frm_ff;
      pf_in        = pf_ff;
      po_in        = po_ff;
      h_in         = h_ff;
      ret_alloc_in = ret_alloc_ff;
      clr_in       = clr_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_en        = 1'b0;
      rd_addr      = '0;
      nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
      pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
      mt_we = 1'b0; mt_wa = '0; mt_wd = '0;

      // unlink writes use the links of the frame read last cycle
      // (ST_A_UNL, ST_P_CHK and ST_F_MRG)
      unique case (state_ff)
         ST_CLEAR: begin
            mt_we  = 1'b1;
            mt_wa  = clr_ff;
            clr_in = clr_ff + FW'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               ord_in = req_word.block_order;
               frm_in = req_word.frame_index;
               cur_in = req_word.block_order;
               res_in = '{status: bpa_pkg::STATUS_FAIL, result_frame: '0,
                          result_order: '0};
               if (32'(req_word.block_order) >= bpa_pkg::NUM_ORDERS) begin
                  state_in = ST_DONE;
               end else if (req_word.req_type == bpa_pkg::REQ_ALLOC) begin
                  state_in = ST_SCAN;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = req_word.frame_index;
                  state_in = ST_F_CHK;
               end
            end
         end
         ST_SCAN: begin
            if (!head_ff[cur_ff][LW-1]) begin
               frm_in   = head_ff[cur_ff][FW-1:0];
               rd_en    = 1'b1;
               rd_addr  = head_ff[cur_ff][FW-1:0];
               state_in = ST_A_UNL;
            end else if (32'(cur_ff) == bpa_pkg::NUM_ORDERS - 1) begin
               state_in = ST_DONE;
            end else begin
               cur_in = cur_ff + OW'(1);
            end
         end
         ST_A_UNL: begin
            if (!pv_rd[LW-1]) begin
               nx_we = 1'b1; nx_wa = pv_rd[FW-1:0]; nx_wd = nx_rd;
            end else if (32'(mt_rd.order) < bpa_pkg::NUM_ORDERS) begin
               if (head_ff[mt_rd.order] == {1'b0, frm_ff}) begin
                  head_in[mt_rd.order] = nx_rd;
               end
            end
            if (!nx_rd[LW-1]) begin
               pv_we = 1'b1; pv_wa = nx_rd[FW-1:0]; pv_wd = pv_rd;
            end
            mt_we = 1'b1;
            mt_wa = frm_ff;
            mt_wd = '{is_free: 1'b0, order: ord_ff};
            state_in = ST_A_SPLIT;
         end
         ST_A_SPLIT: begin
            if (cur_ff == ord_ff) begin
               res_in = '{status: bpa_pkg::STATUS_OK, result_frame: frm_ff,
                          result_order: ord_ff};
               state_in = ST_DONE;
            end else begin
               cur_in = cur_m1;
               if (!half[LW-1]) begin
                  pf_in        = half[FW-1:0];
                  po_in        = cur_m1;
                  ret_alloc_in = 1'b1;
                  rd_en        = 1'b1;
                  rd_addr      = half[FW-1:0];
                  state_in     = ST_P_CHK;
               end
            end
         end
         ST_F_CHK: begin
            state_in = mt_rd.is_free ? ST_DONE : ST_F_LOOP;
         end
         ST_F_LOOP: begin
            rd_en = 1'b1;
            if (32'(ord_ff) < bpa_pkg::NUM_ORDERS - 1) begin
               rd_addr  = buddy;
               state_in = ST_F_MRG;
            end else begin
               rd_addr      = frm_ff;
               pf_in        = frm_ff;
               po_in        = ord_ff;
               ret_alloc_in = 1'b0;
               state_in     = ST_P_CHK;
            end
         end
         ST_F_MRG: begin
            if (mt_rd.is_free && mt_rd.order == ord_ff) begin
               if (!pv_rd[LW-1]) begin
                  nx_we = 1'b1; nx_wa = pv_rd[FW-1:0]; nx_wd = nx_rd;
               end else if (head_ff[ord_ff] == {1'b0, buddy}) begin
                  head_in[ord_ff] = nx_rd;
               end
               if (!nx_rd[LW-1]) begin
                  pv_we = 1'b1; pv_wa = nx_rd[FW-1:0]; pv_wd = pv_rd;
               end
               mt_we    = 1'b1;
               mt_wa    = buddy;
               mt_wd    = '{is_free: 1'b0, order: ord_ff};
               frm_in   = frm_ff & buddy;
               ord_in   = ord_ff + OW'(1);
               state_in = ST_F_LOOP;
            end else begin
               rd_en        = 1'b1;
               rd_addr      = frm_ff;
               pf_in        = frm_ff;
               po_in        = ord_ff;
               ret_alloc_in = 1'b0;
               state_in     = ST_P_CHK;
            end
         end
         ST_P_CHK: begin
            // pushed frame already heads a free block: take it off first
            if (mt_rd.is_free) begin
               if (!pv_rd[LW-1]) begin
                  nx_we = 1'b1; nx_wa = pv_rd[FW-1:0]; nx_wd = nx_rd;
               end else if (32'(mt_rd.order) < bpa_pkg::NUM_ORDERS) begin
                  if (head_ff[mt_rd.order] == {1'b0, pf_ff}) begin
                     head_in[mt_rd.order] = nx_rd;
                  end
               end
               if (!nx_rd[LW-1]) begin
                  pv_we = 1'b1; pv_wa = nx_rd[FW-1:0]; pv_wd = pv_rd;
               end
            end
            state_in = ST_P_LINK;
         end
         ST_P_LINK: begin
            nx_we = 1'b1; nx_wa = pf_ff; nx_wd = head_ff[po_ff];
            pv_we = 1'b1; pv_wa = pf_ff; pv_wd = bpa_pkg::LINK_NONE;
            mt_we = 1'b1; mt_wa = pf_ff;
            mt_wd = '{is_free: 1'b1, order: po_ff};
            head_in[po_ff] = {1'b0, pf_ff};
            h_in  = head_ff[po_ff][FW-1:0];
            if (!head_ff[po_ff][LW-1]) begin
               state_in = ST_P_PREV;
            end else if (ret_alloc_ff) begin
               state_in = ST_A_SPLIT;
            end else begin
               res_in = '{status: bpa_pkg::STATUS_OK, result_frame: frm_ff,
                          result_order: ord_ff};
               state_in = ST_DONE;
            end
         end
         ST_P_PREV: begin
            pv_we = 1'b1; pv_wa = h_ff; pv_wd = {1'b0, pf_ff};
            if (ret_alloc_ff) begin
               state_in = ST_A_SPLIT;
            end else begin
               res_in = '{status: bpa_pkg::STATUS_OK, result_frame: frm_ff,
                          result_order: ord_ff};
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < bpa_pkg::NUM_ORDERS; i++) begin
            head_ff[i] <= bpa_pkg::LINK_NONE;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
      end
      cur_ff       <= cur_in;
      ord_ff       <= ord_in;
      frm_ff       <= frm_in;
      pf_ff        <= pf_in;
      po_ff        <= po_in;
      h_ff         <= h_in;
      ret_alloc_ff <= ret_alloc_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
